// ----- sv/plg_pkg.sv -----
// ============================================================================
// plg_pkg
// Shared widths, codes and types of the probabilistic logic gate.
// ============================================================================
package plg_pkg;

    localparam int NODE_COUNT  = 16;
    localparam int MAX_IN_BITS = 4;
    localparam int OUT_SLOTS   = 4;

    localparam int NODE_W   = 4;
    localparam int STATES_W = 16;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 4;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int TBL_DEPTH = 1 << ADDR_W;
    localparam int WEIGHT_W = 8;
    localparam int SUM_W    = 12;
    localparam int ALU_W    = SUM_W + 1;
    localparam int RND_W    = 31;
    localparam int CNT_W    = 3;
    localparam int MAP_W    = 16;
    localparam int STEP_W   = 5;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_MAP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAP   = 2'd3;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             borrow;
    } alu_rsp_t;

endpackage

// ----- sv/plg_ram.sv -----
// ============================================================================
// plg_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module plg_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- sv/plg_alu.sv -----
// ============================================================================
// plg_alu
// Shared subtract and compare unit used by the write, row-sum, division and walk steps.
// ============================================================================
module plg_alu (
    input  plg_pkg::alu_req_t req,
    output plg_pkg::alu_rsp_t rsp
);
    import plg_pkg::*;

    logic [ALU_W:0] wide;

    assign wide       = {1'b0, req.a} - {1'b0, req.b};
    assign rsp.diff   = wide[ALU_W-1:0];
    assign rsp.borrow = wide[ALU_W];

endmodule

// ----- sv/probabilistic_logic_gate.sv -----
// ============================================================================
// probabilistic_logic_gate
// Weighted stochastic gate with a 16 x 16 weight table and row sums.
// ============================================================================
// After reset the block sweeps the weight RAM to zero and takes no request
// meanwhile; configuration writes are taken at any time. A weight write stores
// the weight and updates the row sum. An evaluate latches and forms the row
// index, reads the row sum, runs 31 restoring division steps for the modulo,
// reads the RAM once per column walked (1 to 16), and posts the result, which
// stretches while the previous result is still held on the output. A row sum
// below 2 skips the division and walk. The subtractions of the row-sum update,
// division and walk share one 13-bit subtractor, and the walk is paced by the
// RAM read port. One request is worked at a time; a finished result waits in
// the output register while the next request is accepted.
module probabilistic_logic_gate (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [plg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [plg_pkg::MAP_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // row[3:0], column[7:4], weight[15:8], node_states[31:16],
    // random_word[62:32], zero[63]
    input  logic [plg_pkg::S_DATA_W-1:0]     s_tdata,
    // command[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // chosen_column[3:0], set_mask[19:4], zero[23:20]
    output logic [plg_pkg::M_DATA_W-1:0]     m_tdata,
    // sum_error[0]
    output logic                             m_tuser
);
    import plg_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SUM,
        ST_DIV,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0]    input_count_reg;
    logic [CNT_W-1:0]    output_count_reg;
    logic [MAP_W-1:0]    input_map_reg;
    logic [MAP_W-1:0]    output_map_reg;
    logic [SUM_W-1:0]    row_sums_reg [1 << ROW_W];

    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic [WEIGHT_W-1:0] wr_weight_reg;
    logic [ROW_W-1:0]    idx_reg;
    logic [RND_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    d_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COL_W-1:0]    j_reg;
    logic                err_reg;

    logic [COL_W-1:0]    out_col_reg;
    logic [STATES_W-1:0] out_mask_reg;
    logic                out_err_reg;
    logic                out_valid_reg;

    logic [ROW_W-1:0]    s_row;
    logic [COL_W-1:0]    s_col;
    logic [WEIGHT_W-1:0] s_weight;
    logic [STATES_W-1:0] s_states;
    logic [RND_W-1:0]    s_rnd;
    logic                s_fire;

    logic [CNT_W-1:0]    nin;
    logic [CNT_W-1:0]    nout;
    logic [ROW_W-1:0]    idx_next;
    logic [STATES_W-1:0] mask_next;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic [SUM_W-1:0]    rem_next;
    logic                walk_stop;
    logic [COL_W-1:0]    j_next;
    logic                out_free;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WEIGHT_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WEIGHT_W-1:0] ram_rdata;

    assign s_row    = s_tdata[ROW_W-1:0];
    assign s_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign s_weight = s_tdata[ADDR_W+WEIGHT_W-1:ADDR_W];
    assign s_states = s_tdata[ADDR_W+WEIGHT_W+STATES_W-1:ADDR_W+WEIGHT_W];
    assign s_rnd    = s_tdata[ADDR_W+WEIGHT_W+STATES_W+RND_W-1:ADDR_W+WEIGHT_W+STATES_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - COL_W - STATES_W){1'b0}}, out_mask_reg, out_col_reg};
    assign m_tuser  = out_err_reg;

    always_comb begin
        if (input_count_reg == '0) begin
            nin = CNT_W'(1);
        end else if (input_count_reg > CNT_W'(MAX_IN_BITS)) begin
            nin = CNT_W'(MAX_IN_BITS);
        end else begin
            nin = input_count_reg;
        end
        if (output_count_reg == '0) begin
            nout = CNT_W'(1);
        end else if (output_count_reg > CNT_W'(OUT_SLOTS)) begin
            nout = CNT_W'(OUT_SLOTS);
        end else begin
            nout = output_count_reg;
        end
    end

    always_comb begin
        logic [NODE_W-1:0] node;
        idx_next = '0;
        for (int i = 0; i < MAX_IN_BITS; i++) begin
            node = input_map_reg[NODE_W*i +: NODE_W];
            if (CNT_W'(i) < nin) begin
                idx_next = {idx_next[ROW_W-2:0],
                    ({1'b0, node} < (NODE_W+1)'(NODE_COUNT)) ? s_states[node] : 1'b0};
            end
        end
    end

    always_comb begin
        logic [NODE_W-1:0] node;
        mask_next = '0;
        for (int i = 0; i < OUT_SLOTS; i++) begin
            node = output_map_reg[NODE_W*i +: NODE_W];
            if (CNT_W'(i) < nout && j_reg[i] &&
                ({1'b0, node} < (NODE_W+1)'(NODE_COUNT))) begin
                mask_next[node] = 1'b1;
            end
        end
    end

    always_comb begin
        alu_req = '0;
        unique case (state_reg)
            ST_WRITE: begin
                alu_req.a = {1'b0, row_sums_reg[wr_addr_reg[ADDR_W-1:COL_W]]}
                          + ALU_W'(wr_weight_reg);
                alu_req.b = ALU_W'(ram_rdata);
            end
            ST_SUM: begin
                alu_req.a = {1'b0, row_sums_reg[idx_reg]};
                alu_req.b = ALU_W'(1);
            end
            ST_DIV: begin
                alu_req.a = {rem_reg, quo_reg[RND_W-1]};
                alu_req.b = {1'b0, d_reg};
            end
            ST_WALK: begin
                alu_req.a = {1'b0, rem_reg};
                alu_req.b = ALU_W'(ram_rdata);
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    plg_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign rem_next  = alu_rsp.borrow ? alu_req.a[SUM_W-1:0] : alu_rsp.diff[SUM_W-1:0];
    assign walk_stop = alu_rsp.borrow || (j_reg == {COL_W{1'b1}});
    assign j_next    = (state_reg == ST_WALK && !walk_stop) ? j_reg + COL_W'(1) : j_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = wr_weight_reg;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_WRITE) begin
            ram_we    = 1'b1;
        end
        if (state_reg == ST_IDLE) begin
            ram_raddr = {s_row, s_col};
        end else begin
            ram_raddr = {idx_reg, j_next};
        end
    end

    plg_ram #(
        .DATA_W (WEIGHT_W),
        .DEPTH  (TBL_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            input_count_reg  <= CNT_W'(1);
            output_count_reg <= CNT_W'(1);
            input_map_reg    <= '0;
            output_map_reg   <= '0;
            out_valid_reg    <= 1'b0;
            for (int k = 0; k < (1 << ROW_W); k++) begin
                row_sums_reg[k] <= '0;
            end
        end else begin
            if (cfg_wen) begin
                unique case (cfg_index)
                    REG_INPUT_COUNT:  input_count_reg  <= cfg_wdata[CNT_W-1:0];
                    REG_OUTPUT_COUNT: output_count_reg <= cfg_wdata[CNT_W-1:0];
                    REG_INPUT_MAP:    input_map_reg    <= cfg_wdata;
                    REG_OUTPUT_MAP:   output_map_reg   <= cfg_wdata;
                    default: ;
                endcase
            end

            if (out_valid_reg && m_tready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        wr_addr_reg   <= {s_row, s_col};
                        wr_weight_reg <= s_weight;
                        idx_reg       <= idx_next;
                        quo_reg       <= s_rnd;
                        j_reg         <= '0;
                        state_reg     <= (s_tuser == CMD_EVAL) ? ST_SUM : ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    row_sums_reg[wr_addr_reg[ADDR_W-1:COL_W]] <= alu_rsp.diff[SUM_W-1:0];
                    state_reg <= ST_IDLE;
                end
                ST_SUM: begin
                    d_reg    <= alu_rsp.diff[SUM_W-1:0];
                    rem_reg  <= '0;
                    step_reg <= STEP_W'(RND_W - 1);
                    if (row_sums_reg[idx_reg] < SUM_W'(2)) begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_DONE;
                    end else begin
                        err_reg   <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_next;
                    quo_reg  <= {quo_reg[RND_W-2:0], 1'b0};
                    step_reg <= step_reg - STEP_W'(1);
                    if (step_reg == '0) begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (walk_stop) begin
                        state_reg <= ST_DONE;
                    end else begin
                        rem_reg <= alu_rsp.diff[SUM_W-1:0];
                        j_reg   <= j_next;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_err_reg   <= err_reg;
                        out_col_reg   <= err_reg ? '0 : j_reg;
                        out_mask_reg  <= err_reg ? '0 : mask_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == CMD_EVAL) |=> !s_tready)
        else $error("evaluate request did not hold the input side busy");

    a_write_two_cycles: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == CMD_WRITE) |=> ##1 s_tready)
        else $error("weight write did not finish in two cycles");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < d_reg))
        else $error("division remainder out of range");

    a_walk_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (d_reg != '0 && !err_reg))
        else $error("column walk entered with a short row sum");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("error result carries a nonzero column or mask");
`endif

endmodule
